// File: hdl/pfe_pkg.sv
`default_nettype none
package pfe_pkg;

   typedef enum logic [3:0] {
      OP_WRITE     = 4'd0,
      OP_READ      = 4'd1,
      OP_FILL      = 4'd2,
      OP_WRITE_REF = 4'd3,
      OP_START_OUT = 4'd4,
      OP_START_IN  = 4'd5,
      OP_STEP_OUT  = 4'd6,
      OP_STEP_IN   = 4'd7,
      OP_LOOKUP    = 4'd8
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILL,
      ST_COPY_RD,
      ST_COPY,
      ST_FADE_RD,
      ST_FADE_MUL,
      ST_FADE_DIV,
      ST_FADE_WR,
      ST_REPORT_RD,
      ST_REPORT
   } state_type;

   localparam logic [1:0] REG_FIRST = 2'd0;
   localparam logic [1:0] REG_LAST  = 2'd1;
   localparam logic [1:0] REG_STEPS = 2'd2;

   localparam logic [7:0] FIRST_RESET = 8'd0;
   localparam logic [7:0] LAST_RESET  = 8'd255;
   localparam logic [7:0] STEPS_RESET = 8'd30;
   localparam logic [7:0] PACK_ALPHA  = 8'hFF;

   typedef struct packed {
      logic       clr_count;
      logic       inc_count;
      logic       load_colour;
      logic       load_item;
      logic       addr_from_walk;
      logic       cur_wr_item;
      logic       cur_wr_fill;
      logic       cur_wr_blend;
      logic       ref_wr_item;
      logic       ref_wr_copy;
      logic       rd_issue;
      logic       mul_load;
      logic       div_start;
      logic       fade_in;
      logic       walk_clr;
      logic       walk_inc;
      logic       capture;
   } cmd_type;

   typedef struct packed {
      logic       walk_at_end;
      logic       fill_at_end;
      logic       step_allowed;
      logic       range_empty;
      logic       div_done;
   } status_type;

endpackage
`default_nettype wire

// File: hdl/pfe_divider.sv
`default_nettype none
module pfe_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [15:0] dividend,
   input  wire logic [7:0]  divisor,
   output logic [7:0]       quotient,
   output logic             done
);
   logic [15:0] rem_ff, rem_in;
   logic [15:0] quo_ff, quo_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [16:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff, quo_ff[15]} - {9'd0, divisor};
      if (start) begin
         rem_in  = 16'd0;
         quo_in  = dividend;
         cnt_in  = 5'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[16]) begin
            rem_in = trial[15:0];
            quo_in = {quo_ff[14:0], 1'b1};
         end else begin
            rem_in = {rem_ff[14:0], quo_ff[15]};
            quo_in = {quo_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd15) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (reset) begin
         cnt_ff  <= 5'd0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   assign quotient = quo_ff[7:0];
   assign done     = !busy_ff && !start;
endmodule
`default_nettype wire

// File: hdl/pfe_datapath.sv
`default_nettype none
module pfe_datapath #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pfe_pkg::cmd_type  cmd,
   output pfe_pkg::status_type    status,
   input  wire logic [7:0]        item_index,
   input  wire logic [7:0]        item_red,
   input  wire logic [7:0]        item_green,
   input  wire logic [7:0]        item_blue,
   input  wire logic [7:0]        fade_first,
   input  wire logic [7:0]        fade_last,
   input  wire logic [7:0]        fade_steps,
   output logic [7:0]             red_out,
   output logic [7:0]             green_out,
   output logic [7:0]             blue_out,
   output logic                   fade_finished,
   output logic [7:0]             steps_done
);
   localparam int AW = $clog2(PALETTE_ENTRIES);
   localparam logic [8:0] LAST_ENTRY = 9'(PALETTE_ENTRIES - 1);

   logic [23:0] cur_mem [PALETTE_ENTRIES];
   logic [23:0] ref_mem [PALETTE_ENTRIES];
   logic [23:0] cur_rd_ff, ref_rd_ff;
   logic [23:0] colour_ff;
   logic [7:0]  count_ff;
   logic [7:0]  idx_ff;
   logic [23:0] rgb_ff;
   logic [8:0]  walk_ff;
   logic [7:0]  res_r_ff, res_g_ff, res_b_ff;
   logic        res_valid_idx_ff;
   logic        res_fin_ff;
   logic [7:0]  res_steps_ff;
   logic [15:0] prod_ff [6];
   logic [7:0]  quo [6];
   logic [5:0]  dd;
   logic [7:0]  steps_eff, w_a, w_b;
   logic [8:0]  last_clip, addr9;
   logic [AW-1:0] addr;
   logic [7:0]  src_a [3];
   logic [7:0]  src_b [3];
   logic [23:0] blend;
   logic        idx_valid;

   assign steps_eff = (fade_steps == 8'd0) ? 8'd1 : fade_steps;
   assign last_clip = ({1'b0, fade_last} > LAST_ENTRY) ? LAST_ENTRY : {1'b0, fade_last};
   assign idx_valid = {1'b0, idx_ff} <= LAST_ENTRY;
   assign addr9     = cmd.addr_from_walk ? walk_ff : {1'b0, idx_ff};
   assign addr      = addr9[AW-1:0];

   assign status.walk_at_end  = walk_ff >= last_clip;
   assign status.fill_at_end  = walk_ff == LAST_ENTRY;
   assign status.step_allowed = count_ff < steps_eff;
   assign status.range_empty  = {1'b0, fade_first} > last_clip;
   assign status.div_done     = &dd;

   assign w_a = count_ff + 8'd1;
   assign w_b = steps_eff - 8'd1 - count_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         src_a[k] = ref_rd_ff[8*k +: 8];
         src_b[k] = cmd.fade_in ? cur_rd_ff[8*k +: 8] : colour_ff[8*k +: 8];
      end
      for (int k = 0; k < 3; k++)
         blend[8*k +: 8] = quo[2*k] + quo[2*k+1];
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_issue) begin
         cur_rd_ff <= (cmd.cur_wr_item && idx_valid) ? rgb_ff : cur_mem[addr];
         ref_rd_ff <= ref_mem[addr];
      end
      if (cmd.cur_wr_item && idx_valid) cur_mem[addr] <= rgb_ff;
      else if (cmd.cur_wr_fill)         cur_mem[addr] <= rgb_ff;
      else if (cmd.cur_wr_blend)        cur_mem[addr] <= blend;
      if (cmd.ref_wr_item && idx_valid) ref_mem[addr] <= rgb_ff;
      else if (cmd.ref_wr_copy)         ref_mem[addr] <= cur_rd_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         idx_ff <= item_index;
         rgb_ff <= {item_blue, item_green, item_red};
      end
      if (cmd.mul_load) begin
         for (int k = 0; k < 3; k++) begin
            prod_ff[2*k]   <= cmd.fade_in ? src_a[k] * w_a : src_a[k] * w_b;
            prod_ff[2*k+1] <= cmd.fade_in ? src_b[k] * w_b : src_b[k] * w_a;
         end
      end
      if (cmd.capture) begin
         res_valid_idx_ff <= idx_valid;
         res_r_ff <= cur_rd_ff[7:0];
         res_g_ff <= cur_rd_ff[15:8];
         res_b_ff <= cur_rd_ff[23:16];
         res_fin_ff <= !status.step_allowed;
         res_steps_ff <= count_ff;
      end
      if (reset) begin
         colour_ff <= 24'd0;
         count_ff  <= 8'd0;
         walk_ff   <= 9'd0;
      end else begin
         if (cmd.load_colour) colour_ff <= rgb_ff;
         if (cmd.clr_count) count_ff <= 8'd0;
         else if (cmd.inc_count) count_ff <= count_ff + 8'd1;
         if (cmd.walk_clr && cmd.addr_from_walk) walk_ff <= {1'b0, fade_first};
         else if (cmd.walk_clr) walk_ff <= 9'd0;
         else if (cmd.walk_inc) walk_ff <= walk_ff + 9'd1;
      end
   end

   for (genvar n = 0; n < 6; n++) begin : g_div
      pfe_divider u_div (
         .clock    (clock),
         .reset    (reset),
         .start    (cmd.div_start),
         .dividend (prod_ff[n]),
         .divisor  (steps_eff),
         .quotient (quo[n]),
         .done     (dd[n])
      );
   end

   assign red_out       = res_valid_idx_ff ? res_r_ff : 8'd0;
   assign green_out     = res_valid_idx_ff ? res_g_ff : 8'd0;
   assign blue_out      = res_valid_idx_ff ? res_b_ff : 8'd0;
   assign fade_finished = res_fin_ff;
   assign steps_done    = res_steps_ff;
endmodule
`default_nettype wire

// File: hdl/pfe_control.sv
`default_nettype none
module pfe_control (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [3:0]           req_op,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire pfe_pkg::status_type  status,
   output pfe_pkg::cmd_type          cmd
);
   pfe_pkg::state_type state_ff, state_in;
   logic [3:0] op_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       fade_in;

   assign fade_in   = op_ff == pfe_pkg::OP_STEP_IN;
   assign req_stall = state_ff != pfe_pkg::ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) op_ff <= req_op;
      if (reset) begin
         state_ff     <= pfe_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.fade_in  = fade_in;
      case (state_ff)
         pfe_pkg::ST_IDLE: begin
            if (req_valid && !req_stall) begin
               cmd.load_item = 1'b1;
               case (req_op)
                  pfe_pkg::OP_FILL: begin
                     cmd.walk_clr = 1'b1;
                     state_in = pfe_pkg::ST_FILL;
                  end
                  pfe_pkg::OP_START_OUT: begin
                     cmd.walk_clr = 1'b1;
                     state_in = pfe_pkg::ST_COPY_RD;
                  end
                  pfe_pkg::OP_STEP_OUT, pfe_pkg::OP_STEP_IN: begin
                     cmd.walk_clr = 1'b1;
                     cmd.addr_from_walk = 1'b1;
                     state_in = pfe_pkg::ST_FADE_RD;
                  end
                  default: state_in = pfe_pkg::ST_REPORT_RD;
               endcase
            end
         end
         pfe_pkg::ST_FILL: begin
            cmd.addr_from_walk = 1'b1;
            cmd.cur_wr_fill = 1'b1;
            cmd.walk_inc = 1'b1;
            if (status.fill_at_end) state_in = pfe_pkg::ST_REPORT_RD;
         end
         pfe_pkg::ST_COPY_RD: begin
            cmd.addr_from_walk = 1'b1;
            cmd.rd_issue = 1'b1;
            state_in = pfe_pkg::ST_COPY;
         end
         pfe_pkg::ST_COPY: begin
            cmd.addr_from_walk = 1'b1;
            cmd.ref_wr_copy = 1'b1;
            cmd.walk_inc = 1'b1;
            if (status.fill_at_end) begin
               cmd.load_colour = 1'b1;
               cmd.clr_count = 1'b1;
               state_in = pfe_pkg::ST_REPORT_RD;
            end else begin
               state_in = pfe_pkg::ST_COPY_RD;
            end
         end
         pfe_pkg::ST_FADE_RD: begin
            cmd.addr_from_walk = 1'b1;
            if (!status.step_allowed) state_in = pfe_pkg::ST_REPORT_RD;
            else if (status.range_empty) begin
               cmd.inc_count = 1'b1;
               state_in = pfe_pkg::ST_REPORT_RD;
            end else begin
               cmd.rd_issue = 1'b1;
               state_in = pfe_pkg::ST_FADE_MUL;
            end
         end
         pfe_pkg::ST_FADE_MUL: begin
            cmd.mul_load = 1'b1;
            state_in = pfe_pkg::ST_FADE_DIV;
         end
         pfe_pkg::ST_FADE_DIV: begin
            cmd.div_start = 1'b1;
            state_in = pfe_pkg::ST_FADE_WR;
         end
         pfe_pkg::ST_FADE_WR: begin
            cmd.addr_from_walk = 1'b1;
            if (status.div_done) begin
               cmd.cur_wr_blend = 1'b1;
               cmd.walk_inc = 1'b1;
               if (status.walk_at_end) begin
                  cmd.inc_count = 1'b1;
                  state_in = pfe_pkg::ST_REPORT_RD;
               end else begin
                  state_in = pfe_pkg::ST_FADE_RD;
               end
            end
         end
         pfe_pkg::ST_REPORT_RD: begin
            cmd.rd_issue = 1'b1;
            state_in = pfe_pkg::ST_REPORT;
         end
         pfe_pkg::ST_REPORT: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               cmd.capture = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = pfe_pkg::ST_IDLE;
            end
         end
         default: state_in = pfe_pkg::ST_IDLE;
      endcase
      if (state_ff == pfe_pkg::ST_REPORT_RD) begin
         cmd.cur_wr_item = op_ff == pfe_pkg::OP_WRITE;
         cmd.ref_wr_item = op_ff == pfe_pkg::OP_WRITE_REF;
         cmd.clr_count   = op_ff == pfe_pkg::OP_START_IN;
      end
   end

`ifndef ASSERT_OFF
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != pfe_pkg::ST_IDLE |-> req_stall)
      else $error("item accepted while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped");
   a_capture_free: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> !(rsp_valid_ff && rsp_stall))
      else $error("result overwritten");
   a_one_cur_write: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.cur_wr_item, cmd.cur_wr_fill, cmd.cur_wr_blend}) <= 1)
      else $error("write conflict");
`endif
endmodule
`default_nettype wire

// File: hdl/palette_fade_engine.sv
`default_nettype none
// Palette of PALETTE_ENTRIES RGB entries with fade sequencer. Items are handled one at a
// time, each giving one result beat. Fill writes every entry; start out walks the whole
// palette, copying each entry to the reference. A fade step blends each entry in
// fade_first..fade_last, using a restoring divide by fade_steps. A step after the count
// has reached fade_steps, or over an empty range, writes no entry. The result register
// frees the input side once a beat is waiting.
module palette_fade_engine #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [3:0]  req_op,
   input  wire logic [7:0]  req_index,
   input  wire logic [7:0]  req_red,
   input  wire logic [7:0]  req_green,
   input  wire logic [7:0]  req_blue,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_red_out,
   output logic [7:0]       rsp_green_out,
   output logic [7:0]       rsp_blue_out,
   output logic [31:0]      rsp_packed_word,
   output logic             rsp_fade_finished,
   output logic [7:0]       rsp_steps_done,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   pfe_pkg::cmd_type    cmd;
   pfe_pkg::status_type status;
   logic [7:0] first_ff, last_ff, steps_ff;
   logic [1:0] reg_sel;

   assign pready  = 1'b1;
   assign reg_sel = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= pfe_pkg::FIRST_RESET;
         last_ff  <= pfe_pkg::LAST_RESET;
         steps_ff <= pfe_pkg::STEPS_RESET;
      end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
         case (reg_sel)
            pfe_pkg::REG_FIRST: first_ff <= pwdata[7:0];
            pfe_pkg::REG_LAST:  last_ff  <= pwdata[7:0];
            pfe_pkg::REG_STEPS: steps_ff <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         pfe_pkg::REG_FIRST: prdata = {24'd0, first_ff};
         pfe_pkg::REG_LAST:  prdata = {24'd0, last_ff};
         pfe_pkg::REG_STEPS: prdata = {24'd0, steps_ff};
         default:            prdata = 32'd0;
      endcase
   end

   pfe_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pfe_datapath #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .item_index    (req_index),
      .item_red      (req_red),
      .item_green    (req_green),
      .item_blue     (req_blue),
      .fade_first    (first_ff),
      .fade_last     (last_ff),
      .fade_steps    (steps_ff),
      .red_out       (rsp_red_out),
      .green_out     (rsp_green_out),
      .blue_out      (rsp_blue_out),
      .fade_finished (rsp_fade_finished),
      .steps_done    (rsp_steps_done)
   );

   assign rsp_packed_word = {pfe_pkg::PACK_ALPHA, rsp_blue_out, rsp_green_out, rsp_red_out};
endmodule
`default_nettype wire

// File: tb/palette_fade_engine_test.sv
`timescale 1ns / 1ps
module palette_fade_engine_test;

   localparam logic [3:0] OP_SPARE_LO = 4'd9;
   localparam logic [3:0] OP_SPARE_HI = 4'd15;

   typedef struct {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [31:0] packed_word;
      logic        finished;
      logic [7:0]  steps;
   } pixel_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [3:0]  req_op = '0;
   logic [7:0]  req_index = '0;
   logic [7:0]  req_red = '0;
   logic [7:0]  req_green = '0;
   logic [7:0]  req_blue = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_red_out;
   logic [7:0]  rsp_green_out;
   logic [7:0]  rsp_blue_out;
   logic [31:0] rsp_packed_word;
   logic        rsp_fade_finished;
   logic [7:0]  rsp_steps_done;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   palette_fade_engine DUT (.*);

   logic [23:0] live_palette [256];
   logic [23:0] target_palette [256];
   logic [23:0] fade_rgb;
   logic [7:0]  fade_count;
   logic [7:0]  range_first;
   logic [7:0]  range_last;
   logic [7:0]  total_steps;

   pixel_result_type pending_pixels [$];
   int          mismatches = 0;
   int          idle_pct = 0;
   int          stall_pct = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #4ms;
      $display("Some tests failed");
      $finish;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   function automatic int divisor();
      return (total_steps == 0) ? 1 : int'(total_steps);
   endfunction

   function automatic void blend_step(bit fade_in);
      int s, j, last, a, b;
      logic [23:0] mixed;
      s = divisor();
      j = fade_count;
      if (j >= s) return;
      last = range_last;
      for (int i = range_first; i <= last; i++) begin
         for (int k = 0; k < 3; k++) begin
            a = target_palette[i][8*k +: 8];
            if (fade_in) begin
               b = live_palette[i][8*k +: 8];
               mixed[8*k +: 8] = 8'(a * (j + 1) / s + b * (s - 1 - j) / s);
            end else begin
               b = fade_rgb[8*k +: 8];
               mixed[8*k +: 8] = 8'(a * (s - 1 - j) / s + b * (j + 1) / s);
            end
         end
         live_palette[i] = mixed;
      end
      fade_count = 8'(j + 1);
   endfunction

   function automatic void predict_pixel(logic [3:0] op, logic [7:0] idx, logic [23:0] rgb);
      pixel_result_type p;
      logic [23:0] e;
      case (op)
         pfe_pkg::OP_WRITE: live_palette[idx] = rgb;
         pfe_pkg::OP_FILL: foreach (live_palette[i]) live_palette[i] = rgb;
         pfe_pkg::OP_WRITE_REF: target_palette[idx] = rgb;
         pfe_pkg::OP_START_OUT: begin
            target_palette = live_palette;
            fade_rgb = rgb;
            fade_count = 0;
         end
         pfe_pkg::OP_START_IN: fade_count = 0;
         pfe_pkg::OP_STEP_OUT: blend_step(1'b0);
         pfe_pkg::OP_STEP_IN: blend_step(1'b1);
         default: ;
      endcase
      e = live_palette[idx];
      p.red = e[7:0];
      p.green = e[15:8];
      p.blue = e[23:16];
      p.packed_word = {pfe_pkg::PACK_ALPHA, e[23:16], e[15:8], e[7:0]};
      p.finished = (int'(fade_count) >= divisor());
      p.steps = fade_count;
      pending_pixels.push_back(p);
   endfunction

   always @(posedge clock) begin
      pixel_result_type p;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
         end else begin
            p = pending_pixels.pop_front();
            if (rsp_red_out !== p.red || rsp_green_out !== p.green
                || rsp_blue_out !== p.blue || rsp_packed_word !== p.packed_word
                || rsp_fade_finished !== p.finished || rsp_steps_done !== p.steps) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch at %0t: exp %h %h %h %h %b %0d got %h %h %h %h %b %0d",
                     $realtime, p.red, p.green, p.blue, p.packed_word, p.finished,
                     p.steps, rsp_red_out, rsp_green_out, rsp_blue_out, rsp_packed_word,
                     rsp_fade_finished, rsp_steps_done);
            end
         end
      end
   end

   task automatic send_beat(logic [3:0] op, logic [7:0] idx,
                            logic [7:0] r, logic [7:0] g, logic [7:0] b);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_index <= idx;
      req_red <= r;
      req_green <= g;
      req_blue <= b;
      do @(posedge clock); while (req_stall);
      predict_pixel(op, idx, {b, g, r});
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] reg_sel, logic [7:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {reg_sel, 2'b00};
      pwdata <= {24'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (reg_sel)
         pfe_pkg::REG_FIRST: range_first = value;
         pfe_pkg::REG_LAST: range_last = value;
         default: total_steps = value;
      endcase
   endtask

   task automatic set_fade(logic [7:0] first, logic [7:0] last, logic [7:0] steps);
      drain();
      csr_write(pfe_pkg::REG_FIRST, first);
      csr_write(pfe_pkg::REG_LAST, last);
      csr_write(pfe_pkg::REG_STEPS, steps);
   endtask

   task automatic test_directed();
      send_beat(pfe_pkg::OP_FILL, 8'd7, 8'h00, 8'hFF, 8'h80);
      send_beat(pfe_pkg::OP_START_OUT, 8'd0, 8'hFF, 8'h00, 8'hFF);
      send_beat(pfe_pkg::OP_WRITE, 8'd0, 8'hFF, 8'hFF, 8'hFF);
      send_beat(pfe_pkg::OP_WRITE, 8'd255, 8'h00, 8'h00, 8'h00);
      send_beat(pfe_pkg::OP_READ, 8'd0, 8'h00, 8'h00, 8'h00);
      send_beat(pfe_pkg::OP_LOOKUP, 8'd255, 8'hFF, 8'hFF, 8'hFF);
      send_beat(pfe_pkg::OP_WRITE_REF, 8'd255, 8'h12, 8'h34, 8'h56);
      send_beat(pfe_pkg::OP_STEP_OUT, 8'd1, 8'h00, 8'h00, 8'h00);
      send_beat(pfe_pkg::OP_STEP_IN, 8'd1, 8'h00, 8'h00, 8'h00);
      send_beat(pfe_pkg::OP_START_IN, 8'd1, 8'h00, 8'h00, 8'h00);
      send_beat(pfe_pkg::OP_STEP_IN, 8'd3, 8'h00, 8'h00, 8'h00);
      send_beat(OP_SPARE_LO, 8'd0, 8'hAA, 8'h55, 8'hAA);
      send_beat(OP_SPARE_HI, 8'd255, 8'h55, 8'hAA, 8'h55);
      // single-step fade over the whole palette, then a step past the end
      set_fade(8'd0, 8'd255, 8'd1);
      send_beat(pfe_pkg::OP_START_OUT, 8'd9, 8'h10, 8'h20, 8'h30);
      send_beat(pfe_pkg::OP_STEP_OUT, 8'd255, 8'h00, 8'h00, 8'h00);
      send_beat(pfe_pkg::OP_STEP_OUT, 8'd0, 8'h00, 8'h00, 8'h00);
      // empty range still counts
      set_fade(8'd200, 8'd100, 8'd255);
      send_beat(pfe_pkg::OP_START_IN, 8'd0, 8'h00, 8'h00, 8'h00);
      send_beat(pfe_pkg::OP_STEP_IN, 8'd150, 8'h00, 8'h00, 8'h00);
      set_fade(8'd255, 8'd255, 8'd2);
      send_beat(pfe_pkg::OP_STEP_OUT, 8'd255, 8'h00, 8'h00, 8'h00);
      send_beat(pfe_pkg::OP_STEP_OUT, 8'd255, 8'h00, 8'h00, 8'h00);
      send_beat(pfe_pkg::OP_STEP_OUT, 8'd255, 8'h00, 8'h00, 8'h00);
   endtask

   task automatic random_beat(int lo, int hi);
      int pick;
      logic [3:0] op;
      logic [7:0] idx;
      pick = $urandom_range(99);
      if (pick < 18) op = pfe_pkg::OP_WRITE;
      else if (pick < 30) op = pfe_pkg::OP_READ;
      else if (pick < 42) op = pfe_pkg::OP_LOOKUP;
      else if (pick < 52) op = pfe_pkg::OP_WRITE_REF;
      else if (pick < 54) op = pfe_pkg::OP_FILL;
      else if (pick < 60) op = pfe_pkg::OP_START_OUT;
      else if (pick < 64) op = pfe_pkg::OP_START_IN;
      else if (pick < 78) op = pfe_pkg::OP_STEP_OUT;
      else if (pick < 92) op = pfe_pkg::OP_STEP_IN;
      else op = 4'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
      if ($urandom_range(1)) idx = 8'($urandom_range(hi, lo));
      else idx = 8'($urandom);
      send_beat(op, idx, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic test_random_phase(int idle, int stall, int items);
      int lo, hi;
      idle_pct = idle;
      stall_pct = stall;
      for (int n = 0; n < items; n++) begin
         if (n % 45 == 0) begin
            lo = $urandom_range(255);
            hi = lo + $urandom_range(6);
            if (hi > 255) hi = 255;
            case ($urandom_range(3))
               0: set_fade(8'(lo), 8'(hi), 8'($urandom_range(255, 1)));
               1: set_fade(8'(lo), 8'(hi), 8'($urandom_range(4, 1)));
               2: set_fade(8'(hi), 8'(lo), 8'($urandom_range(8, 1)));
               default: set_fade(8'(lo), 8'(hi), 8'(255));
            endcase
         end
         random_beat(lo, hi);
      end
   endtask

   initial begin
      for (int i = 0; i < 256; i++) begin
         live_palette[i] = '0;
         target_palette[i] = '0;
      end
      fade_rgb = '0;
      fade_count = '0;
      range_first = pfe_pkg::FIRST_RESET;
      range_last = pfe_pkg::LAST_RESET;
      total_steps = pfe_pkg::STEPS_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_phase(0, 0, 135);
      test_random_phase(53, 0, 135);
      test_random_phase(0, 53, 135);
      test_random_phase(33, 33, 135);
      drain();
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
